// File: src/kers_pkg.sv
// ----------------------------------------------------------------------------
// kers_pkg
// Shared constants for the keypad edge/repeat scanner: register indexes,
// override flag bits and reset values of the delay registers.
// ----------------------------------------------------------------------------
package kers_pkg;

  localparam int unsigned CFG_INDEX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_L_EQUALS_A     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OVERRIDE_FLAGS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_MASK     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_COUNT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_MASK    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_WATCH_MASK     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_DELAY    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONT_DELAY     = 3'd7;

  // Override flag bits
  localparam int unsigned FLAG_FORCE_BIT  = 0;
  localparam int unsigned FLAG_IGNORE_BIT = 1;

  // Counter width and delay reset values
  localparam int unsigned CNT_W = 8;
  localparam logic [CNT_W-1:0] START_DELAY_RESET = 8'd40;
  localparam logic [CNT_W-1:0] CONT_DELAY_RESET  = 8'd5;

endpackage

// File: src/kers_cfg.sv
// ----------------------------------------------------------------------------
// kers_cfg
// Configuration register file. Writes to unknown indexes are dropped.
// A write to the force count register loads the frame counter at that edge.
// ----------------------------------------------------------------------------
module kers_cfg
  import kers_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 10,
  parameter int unsigned DATA_W    = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  output logic                   l_equals_a,
  output logic [1:0]             override_flags,
  output logic [KEY_COUNT-1:0]   force_mask,
  output logic [CNT_W-1:0]       force_count,
  output logic                   force_load,
  output logic [KEY_COUNT-1:0]   ignore_mask,
  output logic [KEY_COUNT-1:0]   watch_mask,
  output logic [CNT_W-1:0]       start_delay,
  output logic [CNT_W-1:0]       cont_delay
);

  // force count is only ever used as the load value of the frame counter
  assign force_load  = cfg_write && (cfg_index == CFG_FORCE_COUNT);
  assign force_count = cfg_data[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      l_equals_a     <= 1'b0;
      override_flags <= 2'b00;
      force_mask     <= '0;
      ignore_mask    <= '0;
      watch_mask     <= '0;
      start_delay    <= START_DELAY_RESET;
      cont_delay     <= CONT_DELAY_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_L_EQUALS_A:     l_equals_a     <= cfg_data[0];
          CFG_OVERRIDE_FLAGS: override_flags <= cfg_data[1:0];
          CFG_FORCE_MASK:     force_mask     <= cfg_data[KEY_COUNT-1:0];
          CFG_FORCE_COUNT:    ;  // loads the frame counter directly
          CFG_IGNORE_MASK:    ignore_mask    <= cfg_data[KEY_COUNT-1:0];
          CFG_WATCH_MASK:     watch_mask     <= cfg_data[KEY_COUNT-1:0];
          CFG_START_DELAY:    start_delay    <= cfg_data[CNT_W-1:0];
          CFG_CONT_DELAY:     cont_delay     <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: src/kers_core.sv
// ----------------------------------------------------------------------------
// kers_core
// Frame datapath: input register, override/edge/repeat logic, result register.
// Scanner state updates when a frame moves from the input to the result stage.
// ----------------------------------------------------------------------------
module kers_core
  import kers_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  // settings
  input  logic                 l_equals_a,
  input  logic [1:0]           override_flags,
  input  logic [KEY_COUNT-1:0] force_mask,
  input  logic [CNT_W-1:0]     force_count,
  input  logic                 force_load,
  input  logic [KEY_COUNT-1:0] ignore_mask,
  input  logic [KEY_COUNT-1:0] watch_mask,
  input  logic [CNT_W-1:0]     start_delay,
  input  logic [CNT_W-1:0]     cont_delay,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_COUNT-1:0] raw_keys,
  input  logic                 watch_clear,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_COUNT-1:0] held_keys,
  output logic [KEY_COUNT-1:0] new_keys,
  output logic [KEY_COUNT-1:0] new_or_repeat_keys,
  output logic                 watch_pressed
);

  localparam int unsigned BIT_A = 0;
  localparam int unsigned BIT_L = KEY_COUNT - 1;

  // input stage
  logic                 s1_valid;
  logic [KEY_COUNT-1:0] s1_raw;
  logic                 s1_clear;

  // scanner state
  logic [KEY_COUNT-1:0] previous_held;
  logic [CNT_W-1:0]     repeat_counter;
  logic [CNT_W-1:0]     force_remaining;
  logic                 watch_flag;

  logic                 advance;
  logic                 accept;

  logic [KEY_COUNT-1:0] sample;
  logic [KEY_COUNT-1:0] pressed;
  logic [KEY_COUNT-1:0] fresh;
  logic [KEY_COUNT-1:0] rep;
  logic [KEY_COUNT-1:0] held;
  logic [KEY_COUNT-1:0] newk;
  logic                 force_on;
  logic                 same;
  logic [CNT_W-1:0]     cnt_dec;
  logic [CNT_W-1:0]     repeat_counter_next;
  logic                 watch_flag_next;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    force_on = override_flags[FLAG_FORCE_BIT] && (force_remaining != '0);
    sample   = s1_raw;
    if (force_on) begin
      sample = sample & ~force_mask;
    end
    if (override_flags[FLAG_IGNORE_BIT]) begin
      sample = sample | ignore_mask;
    end
    pressed = ~sample;
    fresh   = pressed & ~previous_held;
    rep     = fresh;
    same    = (pressed != '0) && (previous_held == pressed);
    cnt_dec = repeat_counter - 1'b1;
    if (same) begin
      if (cnt_dec == '0) begin
        rep                 = pressed;
        repeat_counter_next = cont_delay;
      end else begin
        repeat_counter_next = cnt_dec;
      end
    end else begin
      repeat_counter_next = start_delay;
    end
    held = pressed;
    newk = fresh;
    if (l_equals_a) begin
      if (newk[BIT_L]) begin
        newk[BIT_A] = 1'b1;
      end
      if (held[BIT_L]) begin
        held[BIT_A] = 1'b1;
      end
    end
    watch_flag_next = (watch_flag && !s1_clear) || ((newk & watch_mask) != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      previous_held   <= '0;
      repeat_counter  <= '0;
      force_remaining <= '0;
      watch_flag      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        previous_held  <= pressed;
        repeat_counter <= repeat_counter_next;
        watch_flag     <= watch_flag_next;
      end
      if (force_load) begin
        force_remaining <= force_count;
      end else if (advance && force_on) begin
        force_remaining <= force_remaining - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_raw   <= raw_keys;
      s1_clear <= watch_clear;
    end
    if (advance) begin
      held_keys          <= held;
      new_keys           <= newk;
      new_or_repeat_keys <= rep;
      watch_pressed      <= watch_flag_next;
    end
  end

endmodule

// File: src/keypad_edge_repeat_scanner.sv
// ----------------------------------------------------------------------------
// keypad_edge_repeat_scanner
// Result path: a transfer loads the input reg, an advance the result reg.
// Throughput: one frame per cycle unless out_stall holds a full result reg;
// per-frame loops: 8-bit repeat counter, previous-held compare, force counter, watch flag.
// Reset (rst, synchronous): settings return to defaults (delays 40 and 5),
// key history, repeat/force counters and watch flag clear, both stages empty.
// ----------------------------------------------------------------------------
module keypad_edge_repeat_scanner
  import kers_pkg::*;
#(
  // number of keys; the top key acts as L, bit 0 as A
  parameter int unsigned KEY_COUNT = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port, data as wide as the widest register
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [((KEY_COUNT > CNT_W) ? KEY_COUNT : CNT_W)-1:0] cfg_data,
  // frame sample channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KEY_COUNT-1:0]    raw_keys,
  input  logic                    watch_clear,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KEY_COUNT-1:0]    held_keys,
  output logic [KEY_COUNT-1:0]    new_keys,
  output logic [KEY_COUNT-1:0]    new_or_repeat_keys,
  output logic                    watch_pressed
);

  localparam int unsigned DATA_W = (KEY_COUNT > CNT_W) ? KEY_COUNT : CNT_W;

  // settings from the register file
  logic                 l_equals_a;
  logic [1:0]           override_flags;
  logic [KEY_COUNT-1:0] force_mask;
  logic [CNT_W-1:0]     force_count;
  logic                 force_load;   // high during a force count write
  logic [KEY_COUNT-1:0] ignore_mask;
  logic [KEY_COUNT-1:0] watch_mask;
  logic [CNT_W-1:0]     start_delay;
  logic [CNT_W-1:0]     cont_delay;

  kers_cfg #(
    .KEY_COUNT (KEY_COUNT),
    .DATA_W    (DATA_W)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .l_equals_a     (l_equals_a),
    .override_flags (override_flags),
    .force_mask     (force_mask),
    .force_count    (force_count),
    .force_load     (force_load),
    .ignore_mask    (ignore_mask),
    .watch_mask     (watch_mask),
    .start_delay    (start_delay),
    .cont_delay     (cont_delay)
  );

  // Datapath: a frame is registered on transfer, then evaluated against the
  // key history and moved into the result register; the stall toward the
  // source only rises when both stages hold a frame and the sink stalls.
  kers_core #(
    .KEY_COUNT (KEY_COUNT)
  ) u_core (
    .clk                (clk),
    .rst                (rst),
    .l_equals_a         (l_equals_a),
    .override_flags     (override_flags),
    .force_mask         (force_mask),
    .force_count        (force_count),
    .force_load         (force_load),
    .ignore_mask        (ignore_mask),
    .watch_mask         (watch_mask),
    .start_delay        (start_delay),
    .cont_delay         (cont_delay),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .raw_keys           (raw_keys),
    .watch_clear        (watch_clear),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .held_keys          (held_keys),
    .new_keys           (new_keys),
    .new_or_repeat_keys (new_or_repeat_keys),
    .watch_pressed      (watch_pressed)
  );

endmodule
